// ===== src/ttmn_pkg.sv =====
// ============================================================================
// ttmn_pkg: shared types and constants for the tree token mutex node
// Holds the item and result records, the event and action codes and the
// configuration register indexes.
// ============================================================================
package ttmn_pkg;

  localparam int unsigned IdW      = 4;
  localparam int unsigned StampW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_CHILD = 2'd1,
    REQ_TOKEN = 2'd2,
    REQ_JOB   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_REQUEST = 2'd1,
    ACT_PASS    = 2'd2,
    ACT_ENTER   = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NODE_NUMBER     = 2'd0,
    CFG_TOKEN_AT_START  = 2'd1,
    CFG_PARENT_AT_START = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    req_type_e           req_type;
    logic [StampW-1:0]   iteration;
    logic [IdW-1:0]      requester;
    logic [StampW-1:0]   job_stamp;
  } item_t;

  typedef struct packed {
    action_e             action;
    logic [IdW-1:0]      target;
    logic [StampW-1:0]   served_stamp;
    logic                holding;
    logic                jobs_pending;
    logic                overflow;
  } result_t;

  typedef struct packed {
    logic                valid;
    cfg_reg_e            index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

// ===== src/tree_token_mutex_node_unit.sv =====
// ============================================================================
// tree_token_mutex_node_unit: one node of a tree token mutual-exclusion scheme
// Takes ticks, child requests, token arrivals and job loads, and reports
// per event whether a request went up, the token moved on or the node
// entered its critical section.
// ============================================================================
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  -------------------------------
//  in       sink       in_valid_i / in_stall_o   req_type iteration requester
//                                                job_stamp
//  out      source     out_valid_o / out_stall_i action target served_stamp
//                                                holding jobs_pending overflow
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//
//  One transaction per cycle sustained while out does not stall; an event
//  waits in the input register and its result shows on out from the result register.
//  A stall on out holds the result register and raises in_stall_o only once
//  the input register is also full; an empty input register still takes one.
//  Reset clears the flags, counts, config and both registers' valid bits;
//  the queues need no clearing pass. cfg_ready_o is always high.
// ============================================================================
module tree_token_mutex_node_unit #(
  parameter int unsigned NODE_COUNT    = 16,
  parameter int unsigned REQUEST_DEPTH = 16,
  parameter int unsigned JOB_DEPTH     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // event input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    in_req_type_i,
  input  logic [ttmn_pkg::StampW-1:0]   in_iteration_i,
  input  logic [ttmn_pkg::IdW-1:0]      in_requester_i,
  input  logic [ttmn_pkg::StampW-1:0]   in_job_stamp_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    out_action_o,
  output logic [ttmn_pkg::IdW-1:0]      out_target_o,
  output logic [ttmn_pkg::StampW-1:0]   out_served_stamp_o,
  output logic                          out_holding_o,
  output logic                          out_jobs_pending_o,
  output logic                          out_overflow_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ttmn_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ttmn_pkg::CfgDataW-1:0] cfg_data_i
);

  logic              s1_valid_q;
  ttmn_pkg::item_t   s1_item_q;
  logic              out_valid_q;
  ttmn_pkg::result_t out_res_q;
  ttmn_pkg::result_t core_res;
  ttmn_pkg::cfg_wr_t cfg_wr;
  logic              advance, in_take, step;

  // The result register frees up when empty or when its transaction leaves
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = ttmn_pkg::cfg_reg_e'(cfg_index_i);
  assign cfg_wr.data  = cfg_data_i;

  // Input register: hold the event until the core consumes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.req_type  <= ttmn_pkg::req_type_e'(in_req_type_i);
      s1_item_q.iteration <= in_iteration_i;
      s1_item_q.requester <= in_requester_i;
      s1_item_q.job_stamp <= in_job_stamp_i;
    end
  end

  ttmn_core #(
    .NodeCount    (NODE_COUNT),
    .RequestDepth (REQUEST_DEPTH),
    .JobDepth     (JOB_DEPTH)
  ) u_core (
    .clk_i,
    .rst_ni,
    .cfg_i    (cfg_wr),
    .step_i   (step),
    .item_i   (s1_item_q),
    .result_o (core_res)
  );

  // Result register: advance with the core, drop once taken downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_action_o       = out_res_q.action;
  assign out_target_o       = out_res_q.target;
  assign out_served_stamp_o = out_res_q.served_stamp;
  assign out_holding_o      = out_res_q.holding;
  assign out_jobs_pending_o = out_res_q.jobs_pending;
  assign out_overflow_o     = out_res_q.overflow;

  // Entering the critical section keeps the token
  a_enter_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_action_o == ttmn_pkg::ACT_ENTER) |-> out_holding_o)
    else $error("critical section entered without the token");

  // Sending a request or passing the token means no token is held afterward
  a_move_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_action_o == ttmn_pkg::ACT_PASS) ||
                    (out_action_o == ttmn_pkg::ACT_REQUEST)) |-> !out_holding_o)
    else $error("token still held after request or pass");

  // Input stalls only with both registers occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free register");

  // A served stamp appears only on critical section entry
  a_stamp_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_action_o != ttmn_pkg::ACT_ENTER) |-> (out_served_stamp_o == '0))
    else $error("served stamp outside critical section entry");

endmodule

// ===== src/ttmn_fifo.sv =====
// ============================================================================
// ttmn_fifo: first-word-fall-through queue with a registered head word
// Storage array with one write and one registered read per cycle; a push
// into the slot that becomes the head is forwarded into the head register.
// ============================================================================
module ttmn_fifo #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic [Width-1:0] head_o,
  output logic             empty_o,
  output logic             full_o,
  output logic             last_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] head_q;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             bypass;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign last_o  = (count_q == CntW'(1));
  assign head_o  = head_q;

  always_comb begin
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
    bypass = push_i && (wr_ptr_q == rd_ptr_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i || pop_i) begin
      head_q <= bypass ? push_data_i : mem_q[rd_ptr_d];
    end
  end

endmodule

// ===== src/ttmn_core.sv =====
// ============================================================================
// ttmn_core: token, parent and request state of one tree mutex node
// Applies one event per cycle while step_i is high to the node state and
// the two queues and forms the result of that event.
// ============================================================================
module ttmn_core #(
  parameter int unsigned NodeCount    = 16,
  parameter int unsigned RequestDepth = 16,
  parameter int unsigned JobDepth     = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttmn_pkg::cfg_wr_t cfg_i,
  input  logic              step_i,
  input  ttmn_pkg::item_t   item_i,
  output ttmn_pkg::result_t result_o
);

  logic [ttmn_pkg::IdW-1:0]    node_q;
  logic                        token_q, token_d;
  logic [ttmn_pkg::IdW-1:0]    parent_q, parent_d;
  logic                        own_q, own_d;
  logic                        passed_q, passed_d;

  logic                        req_push, req_pop, req_empty, req_full, req_last;
  logic [ttmn_pkg::IdW-1:0]    req_wdata, req_head;
  logic                        job_push, job_pop, job_empty, job_full, job_last;
  logic [ttmn_pkg::StampW-1:0] job_head;

  logic                        own_push, have_req, fifo_cancel;
  logic [ttmn_pkg::IdW-1:0]    next_id;

  ttmn_fifo #(.Width(ttmn_pkg::IdW), .Depth(RequestDepth)) u_req_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (req_push && !fifo_cancel),
    .push_data_i (req_wdata),
    .pop_i       (req_pop && !fifo_cancel),
    .head_o      (req_head),
    .empty_o     (req_empty),
    .full_o      (req_full),
    .last_o      (req_last)
  );

  ttmn_fifo #(.Width(ttmn_pkg::StampW), .Depth(JobDepth)) u_job_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (job_push),
    .push_data_i (item_i.job_stamp),
    .pop_i       (job_pop),
    .head_o      (job_head),
    .empty_o     (job_empty),
    .full_o      (job_full),
    .last_o      (job_last)
  );

  always_comb begin
    token_d     = token_q;
    parent_d    = parent_q;
    own_d       = own_q;
    passed_d    = passed_q;
    req_push    = 1'b0;
    req_pop     = 1'b0;
    req_wdata   = item_i.requester;
    job_push    = 1'b0;
    job_pop     = 1'b0;
    own_push    = 1'b0;
    have_req    = 1'b0;
    next_id     = '0;
    result_o    = '0;

    if (step_i) begin
      case (item_i.req_type)
        ttmn_pkg::REQ_TICK: begin
          // Queue own id once the oldest job is due
          if (!own_q && !job_empty && (job_head <= item_i.iteration)) begin
            if (req_full) begin
              result_o.overflow = 1'b1;
            end else begin
              own_push  = 1'b1;
              req_push  = 1'b1;
              req_wdata = node_q;
              own_d     = 1'b1;
            end
          end
          have_req = !req_empty || own_push;
          next_id  = req_empty ? node_q : req_head;
          if (token_q) begin
            if (have_req) begin
              req_pop = 1'b1;
              if (next_id == node_q) begin
                result_o.action = ttmn_pkg::ACT_ENTER;
                if (!job_empty) begin
                  job_pop                = 1'b1;
                  result_o.served_stamp  = job_head;
                end
                own_d = 1'b0;
              end else begin
                result_o.action = ttmn_pkg::ACT_PASS;
                result_o.target = next_id;
                token_d         = 1'b0;
                parent_d        = next_id;
                passed_d        = 1'b0;
              end
            end
          end else if (!passed_q && have_req) begin
            result_o.action = ttmn_pkg::ACT_REQUEST;
            result_o.target = parent_q;
            passed_d        = 1'b1;
          end
        end
        ttmn_pkg::REQ_CHILD: begin
          if (32'(item_i.requester) < NodeCount) begin
            if (req_full) begin
              result_o.overflow = 1'b1;
            end else begin
              req_push = 1'b1;
            end
          end
        end
        ttmn_pkg::REQ_TOKEN: begin
          token_d = 1'b1;
        end
        default: begin
          if (job_full) begin
            result_o.overflow = 1'b1;
          end else begin
            job_push = 1'b1;
          end
        end
      endcase
    end

    result_o.holding      = token_d;
    result_o.jobs_pending = (!job_empty && !(job_last && job_pop)) || job_push;
  end

  // Own id pushed into an empty queue and popped at once: leave the queue alone
  assign fifo_cancel = req_empty && req_push && req_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q   <= '0;
      token_q  <= 1'b0;
      parent_q <= '0;
      own_q    <= 1'b0;
      passed_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ttmn_pkg::CFG_NODE_NUMBER:     node_q   <= cfg_i.data;
        ttmn_pkg::CFG_TOKEN_AT_START:  token_q  <= cfg_i.data[0];
        ttmn_pkg::CFG_PARENT_AT_START: parent_q <= cfg_i.data;
        default: ;
      endcase
    end else if (step_i) begin
      token_q  <= token_d;
      parent_q <= parent_d;
      own_q    <= own_d;
      passed_q <= passed_d;
    end
  end

endmodule
